### design/nv2rgb_pkg.sv
// ----------------------------------------------------------------------------
// nv2rgb_pkg
// shared widths, register map and conversion constants for the nv12 to rgb
// pixel converter
// ----------------------------------------------------------------------------
package nv2rgb_pkg;

  // line store
  localparam int MAX_WIDTH = 4096;
  localparam int COL_W     = $clog2(MAX_WIDTH);      // column counter bits
  localparam int PAIR_W    = COL_W - 1;              // u,v pair index bits
  localparam int PAIRS     = MAX_WIDTH / 2;

  // configuration
  localparam int LW_W      = 13;
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;
  localparam logic [LW_W-1:0] LW_RESET = LW_W'(1280);
  localparam logic [LW_W-1:0] LW_MIN   = LW_W'(2);
  localparam logic [LW_W-1:0] LW_MAX   = LW_W'(MAX_WIDTH);

  typedef enum logic {
    REG_LINE_WIDTH = 1'b0,
    REG_NONE       = 1'b1
  } reg_idx_t;

  // request kinds
  typedef enum logic {
    REQ_CHROMA = 1'b0,
    REQ_LUMA   = 1'b1
  } req_type_t;

  // q16 coefficients
  localparam int COEF_W = 18;
  localparam int PROD_W = COEF_W + 9;
  localparam int ACC_W  = PROD_W + 1;
  localparam int FRAC_W = 16;
  localparam logic signed [COEF_W-1:0] COEF_RV = COEF_W'(89831);
  localparam logic signed [COEF_W-1:0] COEF_GV = COEF_W'(45744);
  localparam logic signed [COEF_W-1:0] COEF_GU = COEF_W'(22127);
  localparam logic signed [COEF_W-1:0] COEF_BU = COEF_W'(113538);
  localparam logic [7:0] CHROMA_BIAS = 8'd128;
  localparam logic [7:0] CHAN_MAX    = 8'hFF;

endpackage

### design/nv2rgb_ram.sv
// ----------------------------------------------------------------------------
// nv2rgb_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module nv2rgb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/nv12_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// nv12_to_rgb_converter
// nv12 (yuv 4:2:0 semi-planar) to rgb888 pixel converter with a chroma line
// store
// ----------------------------------------------------------------------------
// usage
//   in channel (in_valid/in_ready): one byte per word. a chroma word
//   (in_req_type = 0) writes the next byte of the interleaved u,v row into
//   the line store and yields no result. a luma word (in_req_type = 1)
//   yields one rgb word on the out channel, using the u,v pair stored at the
//   even-aligned column of the current luma column.
//   line store: two 8-bit rams of MAX_WIDTH/2 entries, even (u) and odd (v)
//   bytes, so one luma word reads its u,v pair in a single ram access.
//   pipeline: a luma word's u,v pair is read from the rams into registers beside
//   its luma byte, then conversion and clamp are registered in the output register.
//   throughput: one word per cycle, chroma or luma, sustained while no rgb word waits on out_ready.
//   stall: while an rgb word waits on out_ready, one more luma word is held
//   in the ram read stage; only then does in_ready drop.
//   reset (rst_n low, synchronous): column counters clear, line_width goes to
//   1280, no words are in flight. line store contents are undefined until a
//   chroma row is written; no clearing pass is run.
//   config: line_width at byte address 0, written via the apb-style port
//   while the block is idle; bit 0 is ignored, range clipped to 2..MAX_WIDTH.
// ----------------------------------------------------------------------------
module nv12_to_rgb_converter (
  input  logic                              clk,
  input  logic                              rst_n,
  // input words
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_req_type,
  input  logic [7:0]                        in_sample_byte,
  // rgb words
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [7:0]                        out_red,
  output logic [7:0]                        out_green,
  output logic [7:0]                        out_blue,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [nv2rgb_pkg::ADDR_W-1:0]     paddr,
  input  logic [nv2rgb_pkg::DATA_W-1:0]     pwdata,
  output logic [nv2rgb_pkg::DATA_W-1:0]     prdata,
  output logic                              pready
);

  // --------------------------------------------------------------------------
  // configuration register
  // --------------------------------------------------------------------------
  logic [nv2rgb_pkg::LW_W-1:0] lw_r;
  logic [nv2rgb_pkg::LW_W-1:0] lw_nxt;
  nv2rgb_pkg::reg_idx_t        reg_sel;
  logic                        cfg_wr;

  assign pready  = 1'b1;
  // register index is the word address; anything past the list decodes as none
  assign reg_sel = nv2rgb_pkg::reg_idx_t'(paddr[nv2rgb_pkg::ADDR_W-1]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    lw_nxt = lw_r;
    if (cfg_wr && (reg_sel == nv2rgb_pkg::REG_LINE_WIDTH)) begin
      lw_nxt = pwdata[nv2rgb_pkg::LW_W-1:0];
    end
  end

  always_comb begin
    case (reg_sel)
      nv2rgb_pkg::REG_LINE_WIDTH: prdata = nv2rgb_pkg::DATA_W'(lw_r);
      default:                    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_r <= nv2rgb_pkg::LW_RESET;
    end else begin
      lw_r <= lw_nxt;
    end
  end

  // effective width: even, clipped to 2..MAX_WIDTH
  logic [nv2rgb_pkg::LW_W-1:0] lw_even;
  logic [nv2rgb_pkg::LW_W-1:0] eff_w;

  assign lw_even = {lw_r[nv2rgb_pkg::LW_W-1:1], 1'b0};

  always_comb begin
    if (lw_even < nv2rgb_pkg::LW_MIN) begin
      eff_w = nv2rgb_pkg::LW_MIN;
    end else if (lw_even > nv2rgb_pkg::LW_MAX) begin
      eff_w = nv2rgb_pkg::LW_MAX;
    end else begin
      eff_w = lw_even;
    end
  end

  // --------------------------------------------------------------------------
  // handshake and pipeline control
  // --------------------------------------------------------------------------
  logic s1_valid_r;
  logic s1_valid_nxt;
  logic out_valid_r;
  logic out_valid_nxt;
  logic out_move;
  logic in_fire;
  logic luma_fire;
  logic chroma_fire;

  // s1 hands its pixel to the output register when that register is free
  assign out_move    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready    = !s1_valid_r || out_move;
  assign in_fire     = in_valid && in_ready;
  assign luma_fire   = in_fire && (in_req_type == nv2rgb_pkg::REQ_LUMA);
  assign chroma_fire = in_fire && (in_req_type == nv2rgb_pkg::REQ_CHROMA);

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (out_move) begin
      s1_valid_nxt = 1'b0;
    end
    if (luma_fire) begin
      s1_valid_nxt = 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_move) begin
      out_valid_nxt = 1'b1;
    end
  end

  assign out_valid = out_valid_r;

  // --------------------------------------------------------------------------
  // column counters, wrap at the effective width
  // --------------------------------------------------------------------------
  logic [nv2rgb_pkg::COL_W-1:0] cwr_col_r;
  logic [nv2rgb_pkg::COL_W-1:0] cwr_col_nxt;
  logic [nv2rgb_pkg::COL_W-1:0] luma_col_r;
  logic [nv2rgb_pkg::COL_W-1:0] luma_col_nxt;
  logic [nv2rgb_pkg::LW_W-1:0]  cwr_inc;
  logic [nv2rgb_pkg::LW_W-1:0]  luma_inc;

  assign cwr_inc  = nv2rgb_pkg::LW_W'(cwr_col_r) + nv2rgb_pkg::LW_W'(1);
  assign luma_inc = nv2rgb_pkg::LW_W'(luma_col_r) + nv2rgb_pkg::LW_W'(1);

  always_comb begin
    cwr_col_nxt = cwr_col_r;
    if (chroma_fire) begin
      // a counter at or past a freshly shrunk width also wraps here
      cwr_col_nxt = (cwr_inc >= eff_w) ? '0 : cwr_inc[nv2rgb_pkg::COL_W-1:0];
    end
  end

  always_comb begin
    luma_col_nxt = luma_col_r;
    if (luma_fire) begin
      luma_col_nxt = (luma_inc >= eff_w) ? '0 : luma_inc[nv2rgb_pkg::COL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cwr_col_r   <= '0;
      luma_col_r  <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cwr_col_r   <= cwr_col_nxt;
      luma_col_r  <= luma_col_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // chroma line store: u bytes at even columns, v bytes at odd columns
  // --------------------------------------------------------------------------
  logic                          u_we;
  logic                          v_we;
  logic [nv2rgb_pkg::PAIR_W-1:0] wr_pair;
  logic [nv2rgb_pkg::PAIR_W-1:0] rd_pair;
  logic [7:0]                    u_rdata;
  logic [7:0]                    v_rdata;

  assign wr_pair = cwr_col_r[nv2rgb_pkg::COL_W-1:1];
  assign rd_pair = luma_col_r[nv2rgb_pkg::COL_W-1:1];
  assign u_we    = chroma_fire && !cwr_col_r[0];
  assign v_we    = chroma_fire && cwr_col_r[0];

  // read only on a luma accept so a stalled pixel keeps its u,v pair
  nv2rgb_ram #(
    .WIDTH (8),
    .DEPTH (nv2rgb_pkg::PAIRS)
  ) u_line_ram (
    .clk   (clk),
    .we    (u_we),
    .waddr (wr_pair),
    .wdata (in_sample_byte),
    .re    (luma_fire),
    .raddr (rd_pair),
    .rdata (u_rdata)
  );

  nv2rgb_ram #(
    .WIDTH (8),
    .DEPTH (nv2rgb_pkg::PAIRS)
  ) v_line_ram (
    .clk   (clk),
    .we    (v_we),
    .waddr (wr_pair),
    .wdata (in_sample_byte),
    .re    (luma_fire),
    .raddr (rd_pair),
    .rdata (v_rdata)
  );

  // luma byte rides alongside the ram read
  logic [7:0] s1_y_r;

  always_ff @(posedge clk) begin
    if (luma_fire) begin
      s1_y_r <= in_sample_byte;
    end
  end

  // --------------------------------------------------------------------------
  // q16 conversion, floor by arithmetic shift, clamp to 0..255
  // --------------------------------------------------------------------------
  function automatic logic [7:0] clamp_q16(input logic signed [nv2rgb_pkg::ACC_W-1:0] acc);
    logic signed [nv2rgb_pkg::ACC_W-nv2rgb_pkg::FRAC_W-1:0] ipart;
    logic [7:0]                                             res;
    ipart = acc[nv2rgb_pkg::ACC_W-1:nv2rgb_pkg::FRAC_W];
    if (ipart < 0) begin
      res = 8'd0;
    end else if (ipart > $signed({1'b0, nv2rgb_pkg::CHAN_MAX})) begin
      res = nv2rgb_pkg::CHAN_MAX;
    end else begin
      res = ipart[7:0];
    end
    return res;
  endfunction

  logic signed [8:0]                    du;
  logic signed [8:0]                    dv;
  logic signed [nv2rgb_pkg::PROD_W-1:0] rv_prod;
  logic signed [nv2rgb_pkg::PROD_W-1:0] gv_prod;
  logic signed [nv2rgb_pkg::PROD_W-1:0] gu_prod;
  logic signed [nv2rgb_pkg::PROD_W-1:0] bu_prod;
  logic signed [nv2rgb_pkg::ACC_W-1:0]  y_q;
  logic signed [nv2rgb_pkg::ACC_W-1:0]  r_acc;
  logic signed [nv2rgb_pkg::ACC_W-1:0]  g_acc;
  logic signed [nv2rgb_pkg::ACC_W-1:0]  b_acc;

  assign du      = $signed({1'b0, u_rdata}) - $signed({1'b0, nv2rgb_pkg::CHROMA_BIAS});
  assign dv      = $signed({1'b0, v_rdata}) - $signed({1'b0, nv2rgb_pkg::CHROMA_BIAS});
  assign rv_prod = nv2rgb_pkg::COEF_RV * dv;
  assign gv_prod = nv2rgb_pkg::COEF_GV * dv;
  assign gu_prod = nv2rgb_pkg::COEF_GU * du;
  assign bu_prod = nv2rgb_pkg::COEF_BU * du;
  assign y_q     = $signed({{(nv2rgb_pkg::ACC_W-nv2rgb_pkg::FRAC_W-8){1'b0}}, s1_y_r,
                            {nv2rgb_pkg::FRAC_W{1'b0}}});
  assign r_acc   = y_q + nv2rgb_pkg::ACC_W'(rv_prod);
  assign g_acc   = y_q - nv2rgb_pkg::ACC_W'(gv_prod) - nv2rgb_pkg::ACC_W'(gu_prod);
  assign b_acc   = y_q + nv2rgb_pkg::ACC_W'(bu_prod);

  logic [7:0] red_r;
  logic [7:0] green_r;
  logic [7:0] blue_r;

  always_ff @(posedge clk) begin
    if (out_move) begin
      red_r   <= clamp_q16(r_acc);
      green_r <= clamp_q16(g_acc);
      blue_r  <= clamp_q16(b_acc);
    end
  end

  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  // a stalled pixel in the ram read stage is never dropped
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !out_move |=> s1_valid_r)
    else $error("pixel lost from ram read stage");

  // every luma word lands in the ram read stage
  a_luma_enter: assert property (@(posedge clk) disable iff (!rst_n)
    luma_fire |=> s1_valid_r)
    else $error("accepted luma word not staged");

  // chroma words never move the luma column, luma words never move the write column
  a_chroma_col: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_req_type == nv2rgb_pkg::REQ_CHROMA) |=> $stable(luma_col_r))
    else $error("chroma word moved luma column");

  a_luma_col: assert property (@(posedge clk) disable iff (!rst_n)
    luma_fire |=> $stable(cwr_col_r))
    else $error("luma word moved chroma write column");

  // a handed-over pixel is presented next cycle
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_move |=> out_valid_r)
    else $error("pixel handed over but not presented");

endmodule

### test/nv12_to_rgb_converter_tb.sv
// ----------------------------------------------------------------------------
// nv12_to_rgb_converter_tb
// self-checking bench for the nv12 to rgb888 converter: chroma rows and luma
// pixels go in over valid/ready, every rgb word is compared with a local
// q16 predictor, line_width is changed between phases over the apb port
// ----------------------------------------------------------------------------
module nv12_to_rgb_converter_tb;

  localparam int RUN_LIMIT  = 1_000_000;  // cycles before the watchdog trips
  localparam int DRAIN_WAIT = 8;          // cycles after the last rgb word
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  // dut ports
  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  logic                          in_req_type;
  logic [7:0]                    in_sample_byte;
  logic                          out_valid;
  logic                          out_ready;
  logic [7:0]                    out_red;
  logic [7:0]                    out_green;
  logic [7:0]                    out_blue;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [nv2rgb_pkg::ADDR_W-1:0] paddr;
  logic [nv2rgb_pkg::DATA_W-1:0] pwdata;
  logic [nv2rgb_pkg::DATA_W-1:0] prdata;
  logic                          pready;

  // local copy of the converter state
  logic [7:0]                   chroma_row  [nv2rgb_pkg::MAX_WIDTH];
  bit                           chroma_seen [nv2rgb_pkg::MAX_WIDTH];  // guards unwritten reads
  logic [nv2rgb_pkg::COL_W-1:0] chroma_col = '0;
  logic [nv2rgb_pkg::COL_W-1:0] luma_col   = '0;
  logic [nv2rgb_pkg::LW_W-1:0]  lw_cfg     = nv2rgb_pkg::LW_RESET;

  pixel_t pending_pixels[$];  // rgb words still owed by the dut

  int mismatches  = 0;
  int words_sent  = 0;
  int cycle_count = 0;
  int src_gap_odds = 4;       // 0 means no source gaps, else 1 in n words
  bit calm = 1'b0;            // set for the last part: no gaps, no stalls

  nv12_to_rgb_converter dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_sample_byte (in_sample_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  // even width in 2..MAX_WIDTH, bit 0 of the register dropped
  function automatic int active_width();
    int w;
    w = int'(lw_cfg) & ~1;
    if (w < 2) w = 2;
    if (w > nv2rgb_pkg::MAX_WIDTH) w = nv2rgb_pkg::MAX_WIDTH & ~1;
    return w;
  endfunction

  // counters wrap at the width, also when they sit beyond a freshly shrunk one
  function automatic logic [nv2rgb_pkg::COL_W-1:0] next_column(
    logic [nv2rgb_pkg::COL_W-1:0] col
  );
    int n;
    n = int'(col) + 1;
    return (n >= active_width()) ? '0 : nv2rgb_pkg::COL_W'(n);
  endfunction

  // floor of a q16 value, clamped to a byte
  function automatic logic [7:0] q16_clamp(int acc);
    int v;
    v = acc >>> nv2rgb_pkg::FRAC_W;
    if (v < 0) return 8'd0;
    if (v > int'(nv2rgb_pkg::CHAN_MAX)) return nv2rgb_pkg::CHAN_MAX;
    return v[7:0];
  endfunction

  function automatic bit pair_written();
    logic [nv2rgb_pkg::COL_W-1:0] base;
    base = luma_col & ~nv2rgb_pkg::COL_W'(1);
    return chroma_seen[base] && chroma_seen[base + 1];
  endfunction

  function automatic void store_chroma(logic [7:0] value);
    chroma_row[chroma_col]  = value;
    chroma_seen[chroma_col] = 1'b1;
    chroma_col = next_column(chroma_col);
  endfunction

  function automatic pixel_t predict_pixel(logic [7:0] luma);
    logic [nv2rgb_pkg::COL_W-1:0] base;
    int du, dv, y;
    pixel_t px;
    base = luma_col & ~nv2rgb_pkg::COL_W'(1);
    du = int'(chroma_row[base]) - int'(nv2rgb_pkg::CHROMA_BIAS);
    dv = int'(chroma_row[base + 1]) - int'(nv2rgb_pkg::CHROMA_BIAS);
    y  = int'(luma) << nv2rgb_pkg::FRAC_W;
    px.red   = q16_clamp(y + int'(nv2rgb_pkg::COEF_RV) * dv);
    px.green = q16_clamp(y - int'(nv2rgb_pkg::COEF_GV) * dv
                           - int'(nv2rgb_pkg::COEF_GU) * du);
    px.blue  = q16_clamp(y + int'(nv2rgb_pkg::COEF_BU) * du);
    luma_col = next_column(luma_col);
    return px;
  endfunction

  function automatic void note_mismatch(string what, int want, int got);
    mismatches++;
    if (mismatches <= REPORT_MAX)
      $display("mismatch on %s: expected %0d, got %0d", what, want, got);
  endfunction

  // ----------------------------------------------------------------- checking

  // every accepted rgb word is matched against the oldest prediction
  always @(posedge clk) begin
    pixel_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("rgb word %0d %0d %0d with nothing pending",
                   out_red, out_green, out_blue);
      end else begin
        want = pending_pixels.pop_front();
        if (out_red !== want.red)     note_mismatch("red", want.red, out_red);
        if (out_green !== want.green) note_mismatch("green", want.green, out_green);
        if (out_blue !== want.blue)   note_mismatch("blue", want.blue, out_blue);
      end
    end
  end

  // sink pacing: ready runs broken by stall bursts of random length
  initial begin : sink_pacing
    int n;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (calm || $urandom_range(0, 2) != 0) begin
        out_ready <= 1'b1;
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 30);
      end else begin
        out_ready <= 1'b0;
        n = $urandom_range(1, 12);
      end
      repeat (n - 1) @(posedge clk);
    end
  end

  initial begin : watchdog
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // ------------------------------------------------------------------ drivers

  // one word on the input channel; valid is left high for a following word
  task automatic send_word(nv2rgb_pkg::req_type_t kind, logic [7:0] value);
    int n;
    if (!calm && src_gap_odds != 0 && $urandom_range(1, src_gap_odds) == 1) begin
      n = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    // never let a luma word read a chroma pair that was not written yet
    if (kind == nv2rgb_pkg::REQ_LUMA && !pair_written()) kind = nv2rgb_pkg::REQ_CHROMA;
    in_valid       <= 1'b1;
    in_req_type    <= kind;
    in_sample_byte <= value;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    if (kind == nv2rgb_pkg::REQ_CHROMA) store_chroma(value);
    else pending_pixels.push_back(predict_pixel(value));
  endtask

  // block idle: nothing owed, and a chroma word still in flight has landed
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(nv2rgb_pkg::reg_idx_t idx,
                           logic [nv2rgb_pkg::DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= nv2rgb_pkg::ADDR_W'(4 * int'(idx));
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == nv2rgb_pkg::REG_LINE_WIDTH) lw_cfg = value[nv2rgb_pkg::LW_W-1:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic read_reg(nv2rgb_pkg::reg_idx_t idx,
                          logic [nv2rgb_pkg::DATA_W-1:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= nv2rgb_pkg::ADDR_W'(4 * int'(idx));
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) note_mismatch("line_width readback", want, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // -------------------------------------------------------------------- tests

  task automatic test_register_reset();
    read_reg(nv2rgb_pkg::REG_LINE_WIDTH, nv2rgb_pkg::DATA_W'(nv2rgb_pkg::LW_RESET));
  endtask

  // widths 0 and 1 act as 2; extreme u,v pairs against extreme luma
  task automatic test_narrow_width();
    settle();
    write_reg(nv2rgb_pkg::REG_LINE_WIDTH, 0);
    send_word(nv2rgb_pkg::REQ_CHROMA, 8'h00);
    send_word(nv2rgb_pkg::REQ_CHROMA, 8'hFF);
    send_word(nv2rgb_pkg::REQ_LUMA, 8'h00);
    send_word(nv2rgb_pkg::REQ_LUMA, 8'hFF);
    send_word(nv2rgb_pkg::REQ_CHROMA, 8'hFF);
    send_word(nv2rgb_pkg::REQ_CHROMA, 8'h00);
    send_word(nv2rgb_pkg::REQ_LUMA, 8'h80);
    send_word(nv2rgb_pkg::REQ_LUMA, 8'h01);
    settle();
    write_reg(nv2rgb_pkg::REG_LINE_WIDTH, 1);
    send_word(nv2rgb_pkg::REQ_CHROMA, nv2rgb_pkg::CHROMA_BIAS);
    send_word(nv2rgb_pkg::REQ_CHROMA, nv2rgb_pkg::CHROMA_BIAS);
    send_word(nv2rgb_pkg::REQ_LUMA, 8'h00);
    send_word(nv2rgb_pkg::REQ_LUMA, 8'hFF);
  endtask

  // odd width 7 behaves as 6
  task automatic test_odd_width();
    settle();
    write_reg(nv2rgb_pkg::REG_LINE_WIDTH, 7);
    send_word(nv2rgb_pkg::REQ_CHROMA, 8'h10);
    send_word(nv2rgb_pkg::REQ_CHROMA, 8'hF0);
    send_word(nv2rgb_pkg::REQ_CHROMA, 8'h7F);
    send_word(nv2rgb_pkg::REQ_CHROMA, 8'h81);
    send_word(nv2rgb_pkg::REQ_CHROMA, 8'hE0);
    send_word(nv2rgb_pkg::REQ_CHROMA, 8'h20);
    repeat (6) send_word(nv2rgb_pkg::REQ_LUMA, 8'($urandom));
  endtask

  // shrink the width while both counters sit past the new width
  task automatic test_width_shrink();
    settle();
    write_reg(nv2rgb_pkg::REG_LINE_WIDTH, 16);
    repeat (16) send_word(nv2rgb_pkg::REQ_CHROMA, 8'($urandom));
    while (luma_col != 11) send_word(nv2rgb_pkg::REQ_LUMA, 8'($urandom));
    while (chroma_col != 10) send_word(nv2rgb_pkg::REQ_CHROMA, 8'($urandom));
    settle();
    write_reg(nv2rgb_pkg::REG_LINE_WIDTH, 5);
    send_word(nv2rgb_pkg::REQ_LUMA, 8'hFF);
    send_word(nv2rgb_pkg::REQ_LUMA, 8'h00);
    send_word(nv2rgb_pkg::REQ_CHROMA, 8'h00);
    send_word(nv2rgb_pkg::REQ_CHROMA, 8'hFF);
    repeat (4) send_word(nv2rgb_pkg::REQ_LUMA, 8'($urandom));
  endtask

  // widths above MAX_WIDTH clip to it
  task automatic test_widest_line();
    settle();
    write_reg(nv2rgb_pkg::REG_LINE_WIDTH, 8191);
    repeat (64) send_word(nv2rgb_pkg::REQ_CHROMA, 8'($urandom));
    repeat (64) send_word(nv2rgb_pkg::REQ_LUMA, 8'($urandom));
    settle();
    write_reg(nv2rgb_pkg::REG_LINE_WIDTH, 4097);
    repeat (32) send_word(nv2rgb_pkg::REQ_LUMA, 8'($urandom));
    settle();
    write_reg(nv2rgb_pkg::REG_LINE_WIDTH, nv2rgb_pkg::MAX_WIDTH);
    read_reg(nv2rgb_pkg::REG_LINE_WIDTH, nv2rgb_pkg::MAX_WIDTH);
    repeat (32) send_word(nv2rgb_pkg::REQ_LUMA, 8'($urandom));
  endtask

  // mostly whole chroma rows followed by luma rows, with stray words mixed in
  task automatic test_random_traffic(int phases, int words_per_phase);
    int start, w, lw;
    for (int p = 0; p < phases; p++) begin
      settle();
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: lw = $urandom_range(0, 40);
        7, 8:                lw = $urandom_range(41, 160);
        default:             lw = $urandom_range(0, 3);
      endcase
      write_reg(nv2rgb_pkg::REG_LINE_WIDTH, lw);
      // last phase runs flat out on both sides
      calm = (p == phases - 1);
      case ($urandom_range(0, 2))
        0:       src_gap_odds = 0;
        1:       src_gap_odds = 3;
        default: src_gap_odds = 8;
      endcase
      w = active_width();
      start = words_sent;
      while (words_sent - start < words_per_phase) begin
        if ($urandom_range(0, 5) == 0) begin
          repeat ($urandom_range(1, 8))
            if (words_sent - start < words_per_phase)
              send_word(nv2rgb_pkg::req_type_t'($urandom_range(0, 1)), 8'($urandom));
        end else begin
          repeat (w)
            if (words_sent - start < words_per_phase)
              send_word(nv2rgb_pkg::REQ_CHROMA, 8'($urandom));
          repeat ($urandom_range(1, 3) * w)
            if (words_sent - start < words_per_phase)
              send_word(nv2rgb_pkg::REQ_LUMA, 8'($urandom));
        end
      end
    end
  endtask

  // ------------------------------------------------------------------ sequence

  initial begin
    in_valid       <= 1'b0;
    in_req_type    <= nv2rgb_pkg::REQ_CHROMA;
    in_sample_byte <= 8'h00;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    rst_n          <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_register_reset();
    test_narrow_width();
    test_odd_width();
    test_width_shrink();
    test_widest_line();
    test_random_traffic(8, 140);

    // drain, then give the block time to show any stray word
    settle();
    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
